FILE: hdl/csv_status_line_parser_top_defines.svh
// Assertion macros shared by the status line parser RTL.
// Depends on nothing; the using module must have clk and arst_n in scope.
`ifndef CSV_STATUS_LINE_PARSER_TOP_DEFINES_SVH
`define CSV_STATUS_LINE_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CSV_SLP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("csv_slp same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define CSV_SLP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("csv_slp next-cycle check failed");

`endif

FILE: hdl/csv_slp_pkg.sv
// Types, character codes and the boolean matcher for the status line parser.
// Depends on nothing.
`default_nettype none

package csv_slp_pkg;

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_ONE = 8'h31;
	localparam logic [7:0] CH_UC_C = 8'h43;

	localparam logic [14:0] NUM_SAT = 15'd32767;

	localparam logic [2:0] FLD_MODE = 3'd0;
	localparam logic [2:0] FLD_NUM_LAST = 3'd4;
	localparam logic [2:0] FLD_HEATER = 3'd5;
	localparam logic [2:0] FLD_PUMP = 3'd6;
	localparam logic [2:0] FLD_MAX = 3'd7;

	localparam logic [3:0] BM_IDLE = 4'd0;
	localparam logic [3:0] BM_ONE = 4'd1;
	localparam logic [3:0] BM_LT = 4'd2;
	localparam logic [3:0] BM_LTR = 4'd3;
	localparam logic [3:0] BM_LTRU = 4'd4;
	localparam logic [3:0] BM_LTRUE = 4'd5;
	localparam logic [3:0] BM_UT = 4'd6;
	localparam logic [3:0] BM_UTR = 4'd7;
	localparam logic [3:0] BM_UTRU = 4'd8;
	localparam logic [3:0] BM_UTRUE = 4'd9;
	localparam logic [3:0] BM_FAIL = 4'd15;

	typedef struct packed {
		logic clr;
		logic char_en;
		logic [2:0] fnum;
		logic [7:0] ch;
	} slp_fctl_t;

	typedef struct packed {
		logic char_seen;
		logic signed [15:0] num;
		logic flag;
	} slp_fsts_t;

	typedef struct packed {
		logic mode_coffee;
		logic signed [15:0] steam_temp;
		logic signed [15:0] target_temp;
		logic signed [15:0] exchanger_temp;
		logic signed [15:0] boost_value;
		logic heater_on;
		logic pump_present;
		logic pump_on;
	} slp_res_t;

	function automatic logic [3:0] bool_next(input logic [3:0] st, input logic first,
			input logic [7:0] c);
		logic [3:0] nx;
		nx = BM_FAIL;
		if (first) begin
			if (c == CH_ONE) nx = BM_ONE;
			else if (c == "t") nx = BM_LT;
			else if (c == "T") nx = BM_UT;
		end else begin
			case (st)
				BM_LT: if (c == "r") nx = BM_LTR;
				BM_LTR: if (c == "u") nx = BM_LTRU;
				BM_LTRU: if (c == "e") nx = BM_LTRUE;
				BM_UT: if (c == "R") nx = BM_UTR;
				BM_UTR: if (c == "U") nx = BM_UTRU;
				BM_UTRU: if (c == "E") nx = BM_UTRUE;
				default: nx = BM_FAIL;
			endcase
		end
		return nx;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/csv_slp_field.sv
// Running accumulators for the field currently being received.
// Depends on csv_slp_pkg.
`default_nettype none

module csv_slp_field
	import csv_slp_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire slp_fctl_t ctl,
	output slp_fsts_t sts
);

	logic [14:0] acc_q;
	logic minus_q;
	logic invalid_q;
	logic seen_q;
	logic [3:0] bm_q;
	logic [18:0] prod;
	logic [15:0] mag;
	logic is_num;
	logic is_bool;
	logic is_digit;

	assign is_num = (ctl.fnum != FLD_MODE) && (ctl.fnum <= FLD_NUM_LAST);
	assign is_bool = (ctl.fnum == FLD_HEATER) || (ctl.fnum == FLD_PUMP);
	assign is_digit = (ctl.ch >= CH_ZERO) && (ctl.ch <= CH_NINE);
	assign prod = {4'd0, acc_q} * 19'd10 + {11'd0, ctl.ch - CH_ZERO};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			minus_q <= 1'b0;
			invalid_q <= 1'b0;
			seen_q <= 1'b0;
			bm_q <= BM_IDLE;
		end else if (ctl.clr) begin
			acc_q <= '0;
			minus_q <= 1'b0;
			invalid_q <= 1'b0;
			seen_q <= 1'b0;
			bm_q <= BM_IDLE;
		end else if (ctl.char_en) begin
			seen_q <= 1'b1;
			if (is_num) begin
				if (!seen_q && ctl.ch == CH_MINUS) begin
					minus_q <= 1'b1;
				end else if (is_digit) begin
					acc_q <= (prod > {4'd0, NUM_SAT}) ? NUM_SAT : prod[14:0];
				end else begin
					invalid_q <= 1'b1;
				end
			end else if (is_bool) begin
				bm_q <= bool_next(bm_q, !seen_q, ctl.ch);
			end
		end
	end

	assign mag = {1'b0, acc_q};
	assign sts.char_seen = seen_q;
	assign sts.num = invalid_q ? '0 : (minus_q ? $signed(16'(-mag)) : $signed(mag));
	assign sts.flag = seen_q && (bm_q == BM_ONE || bm_q == BM_LTRUE || bm_q == BM_UTRUE);

endmodule

`default_nettype wire

FILE: hdl/csv_slp_line.sv
// Line state: length, field index, mode and captured field values.
// Depends on csv_slp_pkg and csv_slp_field.
`default_nettype none

module csv_slp_line
	import csv_slp_pkg::*;
#(
	parameter int MAX_LINE = 128
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic byte_valid,
	input wire logic go,
	input wire logic [7:0] ch,
	output logic res_hit,
	output slp_res_t res
);

	localparam int LEN_W = $clog2(MAX_LINE + 1);

	logic [LEN_W-1:0] len_q;
	logic [2:0] fnum_q;
	logic mode_seen_q;
	logic coffee_q;
	logic signed [15:0] nums_q [4];
	logic [1:0] flags_q;
	logic signed [15:0] nums_w [4];
	logic [1:0] flags_w;
	logic is_lf;
	logic is_cr;
	logic is_comma;
	logic full;
	slp_fctl_t fctl;
	slp_fsts_t fsts;

	assign is_lf = (ch == CH_LF);
	assign is_cr = (ch == CH_CR);
	assign is_comma = (ch == CH_COMMA);
	assign full = (len_q >= LEN_W'(MAX_LINE));

	assign fctl.ch = ch;
	assign fctl.fnum = fnum_q;
	assign fctl.char_en = go && !is_lf && !is_cr && !is_comma && !full;
	assign fctl.clr = go && (is_lf || (!is_cr && (full || is_comma)));

	csv_slp_field u_field (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(fctl),
		.sts(fsts)
	);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			nums_w[i] = (fnum_q == 3'(i + 1)) ? fsts.num : nums_q[i];
		end
		flags_w[0] = (fnum_q == FLD_HEATER) ? fsts.flag : flags_q[0];
		flags_w[1] = (fnum_q == FLD_PUMP) ? fsts.flag : flags_q[1];
	end

	assign res_hit = byte_valid && is_lf && (len_q != '0) && (fnum_q >= FLD_HEATER)
		&& mode_seen_q;
	assign res.mode_coffee = coffee_q;
	assign res.steam_temp = nums_w[0];
	assign res.target_temp = nums_w[1];
	assign res.exchanger_temp = nums_w[2];
	assign res.boost_value = nums_w[3];
	assign res.heater_on = flags_w[0];
	assign res.pump_present = (fnum_q >= FLD_PUMP);
	assign res.pump_on = (fnum_q >= FLD_PUMP) && flags_w[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			fnum_q <= FLD_MODE;
			mode_seen_q <= 1'b0;
			coffee_q <= 1'b0;
			flags_q <= '0;
			for (int i = 0; i < 4; i++) nums_q[i] <= '0;
		end else if (go && !is_cr) begin
			if (is_lf || full) begin
				len_q <= '0;
				fnum_q <= FLD_MODE;
				mode_seen_q <= 1'b0;
				coffee_q <= 1'b0;
				flags_q <= '0;
				for (int i = 0; i < 4; i++) nums_q[i] <= '0;
			end else begin
				len_q <= len_q + LEN_W'(1);
				if (is_comma) begin
					for (int i = 0; i < 4; i++) nums_q[i] <= nums_w[i];
					flags_q <= flags_w;
					if (fnum_q != FLD_MAX) fnum_q <= fnum_q + 3'd1;
				end else if (fnum_q == FLD_MODE && !fsts.char_seen) begin
					mode_seen_q <= 1'b1;
					coffee_q <= (ch == CH_UC_C);
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/csv_status_line_parser_top.sv
// Top level of the status line parser: input register, line logic, result register.
// Depends on csv_slp_pkg, csv_slp_line and csv_status_line_parser_top_defines.svh.
//
// Usage:
// The input channel (in_valid, in_ready, rx_byte) takes one received byte per
// transaction. Bytes are gathered into lines ending in LF; CR is ignored and a
// line longer than MAX_LINE characters is dropped. Each line is split on commas.
// The output channel (out_valid, out_ready and the frame fields) carries one
// transaction for each LF that closes a line with at least six fields and a
// non-empty mode field; every other byte gives no output.
// An accepted LF goes through the input register and then the result register,
// which sets out_valid; an untaken held frame keeps the LF in the input register.
// Throughput: one byte per cycle, set by the single registered pass through the
// line logic. A held frame does not block bytes that produce no frame; only an LF
// that makes a frame waits while the result register is full and out_ready is low.
// Reset: arst_n clears both valid flags and all line state; the first byte after
// reset starts a new line.
`default_nettype none
`include "csv_status_line_parser_top_defines.svh"

module csv_status_line_parser_top
	import csv_slp_pkg::*;
#(
	parameter int MAX_LINE = 128
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] rx_byte,
	output logic out_valid,
	input wire logic out_ready,
	output logic mode_coffee,
	output logic signed [15:0] steam_temp,
	output logic signed [15:0] target_temp,
	output logic signed [15:0] exchanger_temp,
	output logic signed [15:0] boost_value,
	output logic heater_on,
	output logic pump_present,
	output logic pump_on
);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic go;
	logic res_hit;
	slp_res_t res;
	logic out_valid_q;
	slp_res_t res_q;

	assign go = valid_s1 && (!res_hit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	csv_slp_line #(
		.MAX_LINE(MAX_LINE)
	) u_line (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(valid_s1),
		.go(go),
		.ch(byte_s1),
		.res_hit(res_hit),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && res_hit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && res_hit) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign mode_coffee = res_q.mode_coffee;
	assign steam_temp = res_q.steam_temp;
	assign target_temp = res_q.target_temp;
	assign exchanger_temp = res_q.exchanger_temp;
	assign boost_value = res_q.boost_value;
	assign heater_on = res_q.heater_on;
	assign pump_present = res_q.pump_present;
	assign pump_on = res_q.pump_on;

	`CSV_SLP_ASSERT_NOW(a_stall_needs_byte, !in_ready, valid_s1 && res_hit && out_valid_q)
	`CSV_SLP_ASSERT_NOW(a_no_overwrite, go && res_hit, !out_valid_q || out_ready)
	`CSV_SLP_ASSERT_NEXT(a_frame_loaded, go && res_hit, out_valid_q)
	`CSV_SLP_ASSERT_NEXT(a_idle_byte_drains, valid_s1 && !res_hit && !in_valid, !valid_s1)

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for csv_status_line_parser_top: directed status lines, then random
// traffic under several handshake mixes, checked against table rows or a line tracker here.
// Depends on csv_slp_pkg and the parser RTL.

module testbench;
	import csv_slp_pkg::*;

	localparam int LINE_LIMIT = 128;
	localparam int RANDOM_BYTES = 640;
	localparam int MIN_RANDOM_FRAMES = 20;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 5000;
	localparam int TAIL_CYCLES = 16;
	localparam logic [7:0] BYTE_MIN = 8'h00;
	localparam logic [7:0] BYTE_MAX = 8'hFF;

	typedef enum {ROW_PREDICT, ROW_NO_FRAME, ROW_FRAME} row_check_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [7:0] rx_byte;
	logic out_valid;
	logic out_ready;
	logic mode_coffee;
	logic signed [15:0] steam_temp;
	logic signed [15:0] target_temp;
	logic signed [15:0] exchanger_temp;
	logic signed [15:0] boost_value;
	logic heater_on;
	logic pump_present;
	logic pump_on;

	csv_status_line_parser_top #(.MAX_LINE(LINE_LIMIT)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mode_coffee(mode_coffee),
		.steam_temp(steam_temp),
		.target_temp(target_temp),
		.exchanger_temp(exchanger_temp),
		.boost_value(boost_value),
		.heater_on(heater_on),
		.pump_present(pump_present),
		.pump_on(pump_on)
	);

	string row_text[$];
	row_check_t row_kind[$];
	slp_res_t row_expect[$];
	row_check_t row_check = ROW_PREDICT;
	slp_res_t row_frame = '0;

	logic [7:0] line_bytes[$];
	slp_res_t pending_frames[$];

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	bit hold_request = 0;
	int hold_left = 0;
	int error_count = 0;
	int bytes_sent = 0;
	int frames_expected = 0;
	int frames_checked = 0;
	int random_lines = 0;
	int stall_cycles = 0;
	int src_mix[4] = '{0, 86, 0, 35};
	int sink_mix[4] = '{0, 0, 86, 35};

	int unsigned ln_len = 0;
	logic [2:0] ln_field = FLD_MODE;
	bit ln_mode_seen = 0;
	bit ln_coffee = 0;
	logic signed [15:0] ln_nums[4] = '{0, 0, 0, 0};
	bit ln_flags[2] = '{0, 0};
	int fld_acc = 0;
	bit fld_minus = 0;
	bit fld_bad = 0;
	int fld_chars = 0;
	logic [31:0] fld_word = '0;

	function automatic slp_res_t make_frame(int m, int st, int tt, int et, int bv, int h,
			int pp, int po);
		slp_res_t f;
		f.mode_coffee = m[0];
		f.steam_temp = st[15:0];
		f.target_temp = tt[15:0];
		f.exchanger_temp = et[15:0];
		f.boost_value = bv[15:0];
		f.heater_on = h[0];
		f.pump_present = pp[0];
		f.pump_on = po[0];
		return f;
	endfunction

	function automatic string fill_text(string unit, int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++) s = {s, unit};
		return s;
	endfunction

	function automatic bit chance(int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic logic [7:0] pick_plain();
		logic [7:0] c;
		do c = 8'($urandom_range(255)); while (c == CH_LF || c == CH_CR || c == CH_COMMA);
		return c;
	endfunction

	task automatic put_byte(input logic [7:0] c);
		line_bytes.insert(line_bytes.size(), c);
	endtask

	task automatic add_row(string text, row_check_t kind, slp_res_t f);
		row_text.insert(row_text.size(), text);
		row_kind.insert(row_kind.size(), kind);
		row_expect.insert(row_expect.size(), f);
	endtask

	task automatic clear_field_state();
		fld_acc = 0;
		fld_minus = 0;
		fld_bad = 0;
		fld_chars = 0;
		fld_word = '0;
	endtask

	task automatic clear_line_state();
		ln_len = 0;
		ln_field = FLD_MODE;
		ln_mode_seen = 0;
		ln_coffee = 0;
		for (int i = 0; i < 4; i++) ln_nums[i] = '0;
		ln_flags[0] = 0;
		ln_flags[1] = 0;
		clear_field_state();
	endtask

	task automatic close_field();
		logic [2:0] idx;
		if (ln_field >= 3'd1 && ln_field <= FLD_NUM_LAST) begin
			idx = ln_field - 3'd1;
			ln_nums[idx[1:0]] = 16'(fld_bad ? 0 : (fld_minus ? -fld_acc : fld_acc));
		end else if (ln_field == FLD_HEATER || ln_field == FLD_PUMP) begin
			idx = ln_field - FLD_HEATER;
			ln_flags[idx[0]] = (fld_chars == 1 && fld_word[7:0] == CH_ONE) ||
				(fld_chars == 4 && (fld_word == "true" || fld_word == "TRUE"));
		end
		clear_field_state();
	endtask

	task automatic advance_line_state(input logic [7:0] c, output bit made,
			output slp_res_t frame);
		made = 0;
		frame = '0;
		if (c == CH_LF) begin
			if (ln_len != 0) begin
				close_field();
				if (ln_field >= FLD_HEATER && ln_mode_seen) begin
					made = 1;
					frame = make_frame(int'(ln_coffee), int'(ln_nums[0]), int'(ln_nums[1]),
						int'(ln_nums[2]), int'(ln_nums[3]), int'(ln_flags[0]),
						int'(ln_field >= FLD_PUMP), int'(ln_field >= FLD_PUMP && ln_flags[1]));
				end
			end
			clear_line_state();
		end else if (c != CH_CR) begin
			if (ln_len >= LINE_LIMIT) begin
				clear_line_state();
			end else begin
				ln_len++;
				if (c == CH_COMMA) begin
					close_field();
					if (ln_field != FLD_MAX) ln_field++;
				end else begin
					if (ln_field == FLD_MODE) begin
						if (fld_chars == 0) begin
							ln_mode_seen = 1;
							ln_coffee = (c == CH_UC_C);
						end
					end else if (ln_field <= FLD_NUM_LAST) begin
						if (fld_chars == 0 && c == CH_MINUS) begin
							fld_minus = 1;
						end else if (c >= CH_ZERO && c <= CH_NINE) begin
							fld_acc = fld_acc * 10 + int'(c - CH_ZERO);
							if (fld_acc > int'(NUM_SAT)) fld_acc = int'(NUM_SAT);
						end else begin
							fld_bad = 1;
						end
					end else if (ln_field <= FLD_PUMP) begin
						fld_word = {fld_word[23:0], c};
					end
					fld_chars++;
				end
			end
		end
	endtask

	// In table text, '#' stands for the byte 0x00 and '@' for the byte 0xFF.
	task automatic push_text(string s);
		logic [7:0] c;
		for (int i = 0; i < s.len(); i++) begin
			c = s[i];
			if (c == "#") c = BYTE_MIN;
			else if (c == "@") c = BYTE_MAX;
			put_byte(c);
		end
	endtask

	task automatic push_mode_field();
		int r;
		r = $urandom_range(9);
		if (r <= 3) put_byte(CH_UC_C);
		else if (r <= 6) put_byte("S");
		else put_byte(pick_plain());
		repeat ($urandom_range(3)) put_byte(pick_plain());
	endtask

	task automatic push_number_field();
		int r;
		int n;
		r = $urandom_range(9);
		put_byte(CH_COMMA);
		if (r == 1) begin
			put_byte(CH_MINUS);
		end else if (r >= 2) begin
			if ($urandom_range(1)) put_byte(CH_MINUS);
			n = $urandom_range(1, (r >= 7) ? 7 : 4);
			repeat (n) put_byte(8'(CH_ZERO + $urandom_range(9)));
			if (r == 9) begin
				put_byte(pick_plain());
				put_byte(8'(CH_ZERO + $urandom_range(9)));
			end
		end
	endtask

	task automatic push_bool_field();
		put_byte(CH_COMMA);
		case ($urandom_range(9))
			0, 1: push_text("1");
			2: push_text("true");
			3: push_text("TRUE");
			4: push_text("0");
			5: push_text("false");
			6: ;
			7: push_text("True");
			8: push_text("11");
			default: repeat ($urandom_range(1, 5)) put_byte(pick_plain());
		endcase
	endtask

	task automatic push_status_line();
		push_mode_field();
		repeat (4) push_number_field();
		push_bool_field();
		if ($urandom_range(9) < 6) push_bool_field();
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				put_byte(CH_COMMA);
				repeat ($urandom_range(3)) put_byte(pick_plain());
			end
		end
		if ($urandom_range(4) == 0) put_byte(CH_CR);
		put_byte(CH_LF);
	endtask

	task automatic build_random_line();
		int r;
		r = $urandom_range(99);
		line_bytes.delete();
		if (r < 72) begin
			push_status_line();
		end else if (r < 82) begin
			if ($urandom_range(1)) begin
				push_mode_field();
				repeat ($urandom_range(4)) push_number_field();
			end else begin
				repeat (4) push_number_field();
				push_bool_field();
				push_bool_field();
			end
			put_byte(CH_LF);
		end else if (r < 90) begin
			repeat ($urandom_range(1, 30)) put_byte(8'($urandom_range(255)));
			put_byte(CH_LF);
		end else if (r < 95) begin
			repeat ($urandom_range(LINE_LIMIT - 3, LINE_LIMIT + 7))
				put_byte(pick_plain());
			push_status_line();
		end else begin
			if ($urandom_range(1)) put_byte(CH_CR);
			put_byte(CH_LF);
		end
	endtask

	task automatic send_byte(input logic [7:0] c);
		while (chance(src_idle_pct)) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_line();
		foreach (line_bytes[i]) send_byte(line_bytes[i]);
	endtask

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			error_count++;
			$display("%0t: field %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= !chance(sink_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : frame_monitor
		slp_res_t got;
		slp_res_t want;
		slp_res_t model_frame;
		bit made;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = {mode_coffee, steam_temp, target_temp, exchanger_temp, boost_value,
					heater_on, pump_present, pump_on};
				frames_checked++;
				if (pending_frames.size() == 0) begin
					error_count++;
					$display("%0t: frame with nothing expected, expected none, actual %h",
						$time, got);
				end else begin
					want = pending_frames.pop_front();
					check_field("mode_coffee", int'(want.mode_coffee), int'(got.mode_coffee));
					check_field("steam_temp", int'(want.steam_temp), int'(got.steam_temp));
					check_field("target_temp", int'(want.target_temp), int'(got.target_temp));
					check_field("exchanger_temp", int'(want.exchanger_temp),
						int'(got.exchanger_temp));
					check_field("boost_value", int'(want.boost_value), int'(got.boost_value));
					check_field("heater_on", int'(want.heater_on), int'(got.heater_on));
					check_field("pump_present", int'(want.pump_present), int'(got.pump_present));
					check_field("pump_on", int'(want.pump_on), int'(got.pump_on));
				end
			end
			if (in_valid && in_ready) begin
				advance_line_state(rx_byte, made, model_frame);
				if (rx_byte == CH_LF) begin
					if (row_check == ROW_FRAME) begin
						pending_frames.insert(pending_frames.size(), row_frame);
						frames_expected++;
					end else if (row_check == ROW_PREDICT && made) begin
						pending_frames.insert(pending_frames.size(), model_frame);
						frames_expected++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
			else stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d frames outstanding", $time,
					STALL_LIMIT, pending_frames.size());
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int phase_start;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = '0;

		add_row("\n", ROW_NO_FRAME, '0);
		add_row("\015\n", ROW_NO_FRAME, '0);
		add_row("C,1,2,3,4,1\015\n", ROW_FRAME, make_frame(1, 1, 2, 3, 4, 1, 0, 0));
		add_row("S,32767,-32767,99999,-99999,true,TRUE\n", ROW_FRAME,
			make_frame(0, 32767, -32767, 32767, -32767, 1, 1, 1));
		add_row("C,,-,12a,1-2,0,false\n", ROW_FRAME, make_frame(1, 0, 0, 0, 0, 0, 1, 0));
		add_row("C,1,2,3,4\n", ROW_NO_FRAME, '0);
		add_row(",1,2,3,4,1,1\n", ROW_NO_FRAME, '0);
		add_row("Coffee,00042,-0,7,8,1,1,extra,more,x\n", ROW_FRAME,
			make_frame(1, 42, 0, 7, 8, 1, 1, 1));
		add_row("C,1,2,3,4,11,tru\n", ROW_FRAME, make_frame(1, 1, 2, 3, 4, 0, 1, 0));
		add_row("C,1,2,3,4,1,\n", ROW_FRAME, make_frame(1, 1, 2, 3, 4, 1, 1, 0));
		add_row("@,7,#,3,-4,TRUE\n", ROW_FRAME, make_frame(0, 7, 0, 3, -4, 1, 0, 0));
		add_row("C,32768,-32766,--5,9-,True,1\n", ROW_PREDICT, '0);
		add_row("C\015,1,2\015,3,4,1\n", ROW_PREDICT, '0);
		add_row({"S,1,2,3,4,0,", fill_text("z", LINE_LIMIT - 12), "\n"}, ROW_FRAME,
			make_frame(0, 1, 2, 3, 4, 0, 1, 0));
		add_row({fill_text("x", LINE_LIMIT), "C,1,2,3,4,1,1\n"}, ROW_NO_FRAME, '0);
		add_row({fill_text("x", LINE_LIMIT), "!C,9,8,7,6,TRUE\n"}, ROW_FRAME,
			make_frame(1, 9, 8, 7, 6, 1, 0, 0));
		add_row("T,5,-6,7,-8,t,#1\n", ROW_PREDICT, '0);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (row_text[i]) begin
			row_check = row_kind[i];
			row_frame = row_expect[i];
			line_bytes.delete();
			push_text(row_text[i]);
			send_line();
		end
		row_check = ROW_PREDICT;

		// The long output hold-off lands at the start of the random traffic, with no sender gaps.
		hold_request = 1;
		for (int phase = 0; phase < 4; phase++) begin
			src_idle_pct = src_mix[phase];
			sink_stall_pct = sink_mix[phase];
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < RANDOM_BYTES / 4 ||
					(phase == 3 && frames_expected < MIN_RANDOM_FRAMES)) begin
				build_random_line();
				send_line();
				random_lines++;
			end
		end
		in_valid <= 1'b0;

		while (pending_frames.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d directed lines and %0d random lines, %0d bytes in all.",
			row_text.size(), random_lines, bytes_sent);
		$display("Compared %0d frames over four handshake mixes and a long output hold-off.",
			frames_checked);
		if (error_count == 0 && pending_frames.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/csv_slp_pkg.sv
hdl/csv_slp_field.sv
hdl/csv_slp_line.sv
hdl/csv_status_line_parser_top.sv
sim/testbench.sv
